// ===== rtl/core/swm_pkg.sv =====
// shared types and constants for the sliding window median filter
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int WLEN_W     = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // per-cell move flags seen by the neighbors
    typedef struct packed {
        logic kept;
        logic up;
        logic down;
    } t_flags;

    // values broadcast to every cell
    typedef struct packed {
        t_sample sample;
        t_sample rem_val;
        logic    full;
        logic    step;
        logic    clear;
    } t_bcast;

endpackage

`default_nettype wire

// ===== rtl/core/swm_sample_if.sv =====
// input channel carrying one sample per transaction
`timescale 1ns / 1ps
`default_nettype none

interface swm_sample_if;
    logic                valid;
    logic                ready;
    swm_pkg::t_sample    sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swm_median_if.sv =====
// output channel carrying one median per transaction
`timescale 1ns / 1ps
`default_nettype none

interface swm_median_if;
    logic                valid;
    logic                ready;
    swm_pkg::t_sample    median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swm_cell.sv =====
// one sorted-window cell: holds a value and its age, moves with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int IDX = 0,
    parameter int AW  = 6,
    parameter int CW  = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  swm_pkg::t_bcast       i_bc,
    input  wire  [AW-1:0]         i_len_m1,
    input  wire  [AW-1:0]         i_med_pos,
    input  wire  [CW-1:0]         i_new_cnt,
    input  swm_pkg::t_sample      i_left_val,
    input  wire  [AW-1:0]         i_left_age,
    input  swm_pkg::t_flags       i_left_flags,
    input  swm_pkg::t_sample      i_right_val,
    input  wire  [AW-1:0]         i_right_age,
    input  swm_pkg::t_flags       i_right_flags,
    output swm_pkg::t_sample      o_val,
    output logic [AW-1:0]         o_age,
    output swm_pkg::t_flags       o_flags,
    output swm_pkg::t_sample      o_rem_val,
    output swm_pkg::t_sample      o_med_tap
);
    import swm_pkg::*;

    t_sample       r_val, n_val;
    logic [AW-1:0] r_age, n_age;
    logic          r_valid, n_valid;
    logic          rem;
    logic          after_rem;
    t_flags        flags;

    // oldest entry leaves when the window is full
    assign rem       = i_bc.full && r_valid && (r_age == i_len_m1);
    assign after_rem = i_bc.full && r_valid && !rem && (r_val >= i_bc.rem_val);

    always_comb begin
        flags.kept = r_valid && !rem;
        flags.up   = r_valid && !rem && (r_val > i_bc.sample);
        flags.down = after_rem;
        if (flags.up && flags.down) begin
            flags.up   = 1'b0;
            flags.down = 1'b0;
        end
    end

    assign o_val     = r_val;
    assign o_age     = r_age;
    assign o_flags   = flags;
    assign o_rem_val = rem ? r_val : '0;
    assign o_med_tap = (i_med_pos == AW'(IDX)) ? r_val : '0;

    always_comb begin
        n_val   = r_val;
        n_age   = r_age;
        n_valid = r_valid;
        if (i_bc.clear) begin
            n_valid = 1'b0;
        end else if (i_bc.step) begin
            n_valid = (CW'(IDX) < i_new_cnt);
            if (i_left_flags.kept && i_left_flags.up) begin
                n_val = i_left_val;
                n_age = i_left_age + AW'(1);
            end else if (flags.kept && !flags.up && !flags.down) begin
                n_val = r_val;
                n_age = r_age + AW'(1);
            end else if (i_right_flags.kept && i_right_flags.down) begin
                n_val = i_right_val;
                n_age = i_right_age + AW'(1);
            end else begin
                n_val = i_bc.sample;
                n_age = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_median.sv =====
// sliding window median filter top level
// median: the filling sample sets r_pend, and the median register takes the selected cell
// once the output slot is free; throughput: one sample per cycle while the output is not
// stalled, and the cell row updates every sorted position at once
// reset: window empty, window length 3; a length write also empties the window
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median #(
    parameter int MAX_WINDOW = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [swm_pkg::WLEN_W-1:0]       i_cfg_wdata,
    swm_sample_if.sink                       i_sample,
    swm_median_if.source                     o_median
);
    import swm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int EW = (LW > WLEN_W) ? LW : WLEN_W;

    logic [WLEN_W-1:0] r_window_len;
    logic [LW-1:0]     r_fill, n_fill;
    logic              r_pend, n_pend;
    logic              r_out_valid;
    t_sample           r_out_med;

    logic [EW-1:0]     wl_ext;
    logic [LW-1:0]     len_eff;
    logic [LW-1:0]     new_cnt;
    logic [AW-1:0]     len_m1;
    logic [AW-1:0]     med_pos;
    logic              full;
    logic              accept;
    logic              slot_free;
    t_sample           rem_val;
    t_sample           med_val;
    t_bcast            bc;

    t_sample           c_val  [MAX_WINDOW];
    logic [AW-1:0]     c_age  [MAX_WINDOW];
    t_flags            c_flag [MAX_WINDOW];
    t_sample           c_rem  [MAX_WINDOW];
    t_sample           c_tap  [MAX_WINDOW];

    // effective window length, clamped to 1..MAX_WINDOW
    assign wl_ext = EW'(r_window_len);
    always_comb begin
        if (r_window_len == '0) begin
            len_eff = LW'(1);
        end else if (wl_ext > EW'(MAX_WINDOW)) begin
            len_eff = LW'(MAX_WINDOW);
        end else begin
            len_eff = LW'(wl_ext);
        end
    end

    assign len_m1  = AW'(len_eff - LW'(1));
    assign med_pos = AW'((len_eff - LW'(1)) >> 1);
    assign full    = (r_fill == len_eff);
    assign new_cnt = full ? r_fill : r_fill + LW'(1);

    assign slot_free      = !r_out_valid || o_median.ready;
    assign i_sample.ready = !r_pend || slot_free;
    assign accept         = i_sample.valid && i_sample.ready;

    always_comb begin
        rem_val = '0;
        med_val = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            rem_val = rem_val | c_rem[k];
            med_val = med_val | c_tap[k];
        end
    end

    assign bc.sample  = i_sample.sample;
    assign bc.rem_val = rem_val;
    assign bc.full    = full;
    assign bc.step    = accept;
    assign bc.clear   = i_cfg_we;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        t_sample       l_val;
        logic [AW-1:0] l_age;
        t_flags        l_flag;
        t_sample       r_nb_val;
        logic [AW-1:0] r_nb_age;
        t_flags        r_nb_flag;

        if (g == 0) begin : g_first
            assign l_val  = '0;
            assign l_age  = '0;
            assign l_flag = '0;
        end else begin : g_mid_l
            assign l_val  = c_val[g-1];
            assign l_age  = c_age[g-1];
            assign l_flag = c_flag[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign r_nb_val  = '0;
            assign r_nb_age  = '0;
            assign r_nb_flag = '0;
        end else begin : g_mid_r
            assign r_nb_val  = c_val[g+1];
            assign r_nb_age  = c_age[g+1];
            assign r_nb_flag = c_flag[g+1];
        end

        swm_cell #(
            .IDX (g),
            .AW  (AW),
            .CW  (LW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_bc          (bc),
            .i_len_m1      (len_m1),
            .i_med_pos     (med_pos),
            .i_new_cnt     (new_cnt),
            .i_left_val    (l_val),
            .i_left_age    (l_age),
            .i_left_flags  (l_flag),
            .i_right_val   (r_nb_val),
            .i_right_age   (r_nb_age),
            .i_right_flags (r_nb_flag),
            .o_val         (c_val[g]),
            .o_age         (c_age[g]),
            .o_flags       (c_flag[g]),
            .o_rem_val     (c_rem[g]),
            .o_med_tap     (c_tap[g])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cfg_we) begin
            n_fill = '0;
        end else if (accept) begin
            n_fill = new_cnt;
        end
    end

    // a median is owed once the window is full after this transaction
    assign n_pend = (r_pend && !slot_free) || (accept && (new_cnt == len_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_RESET;
            r_fill       <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_len <= i_cfg_wdata;
            end
            r_fill <= n_fill;
            r_pend <= n_pend;
            if (r_pend && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_median.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && slot_free) begin
            r_out_med <= med_val;
        end
    end

    assign o_median.valid  = r_out_valid;
    assign o_median.median = r_out_med;

endmodule

`default_nettype wire

// ===== tb/sv/tb_sliding_window_median.sv =====
// testbench for sliding_window_median: sample streams checked against a window predictor
`timescale 1ns / 1ps

module tb_sliding_window_median;
    import swm_pkg::*;

    localparam int MAX_WINDOW    = 64;
    localparam int STUCK_LIMIT   = 1000;
    localparam int HOLD_LEN      = 150;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_TARGET = 680;
    localparam t_sample SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam t_sample SAMPLE_MIN = 32'sh8000_0000;

    typedef enum int {VALUES_ANY, VALUES_NARROW, VALUES_EXTREME} t_value_mix;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [WLEN_W-1:0]   i_cfg_wdata;

    swm_sample_if sample_ch ();
    swm_median_if median_ch ();

    sliding_window_median #(
        .MAX_WINDOW(MAX_WINDOW)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_sample(sample_ch),
        .o_median(median_ch)
    );

    // window predictor state
    logic [WLEN_W-1:0] cur_len;
    t_sample           arrival_q[$];
    t_sample           sorted_q[$];
    t_sample           expected_medians[$];

    int  error_count;
    int  samples_sent;
    int  stuck_cycles;
    int  hold_cycles;
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int effective_len(input logic [WLEN_W-1:0] len);
        if (len == 0) begin
            return 1;
        end
        if (int'(len) > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(len);
    endfunction

    task automatic report_mismatch(input string what, input t_sample got, input t_sample want);
        $display("mismatch at %0t: %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // oldest sample leaves the sorted copy first, then the new one goes after equal values
    task automatic predict_median(input t_sample value);
        int      eff;
        int      pos;
        t_sample oldest;
        eff = effective_len(cur_len);
        if (arrival_q.size() == eff) begin
            oldest = arrival_q.pop_front();
            for (pos = 0; pos < sorted_q.size(); pos++) begin
                if (sorted_q[pos] == oldest) begin
                    break;
                end
            end
            sorted_q.delete(pos);
        end
        arrival_q = {arrival_q, value};
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] <= value) begin
            pos++;
        end
        sorted_q.insert(pos, value);
        if (arrival_q.size() == eff) begin
            expected_medians = {expected_medians, sorted_q[(eff - 1) / 2]};
        end
    endtask

    always @(posedge i_clk) begin : track_window
        t_sample want;
        if (!i_rst_n) begin
            cur_len = WLEN_RESET;
            arrival_q.delete();
            sorted_q.delete();
            expected_medians.delete();
        end else begin
            if (i_cfg_we) begin
                cur_len = i_cfg_wdata;
                arrival_q.delete();
                sorted_q.delete();
            end
            if (sample_ch.valid && sample_ch.ready) begin
                predict_median(sample_ch.sample);
            end
            if (median_ch.valid && median_ch.ready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch("median with no window pending", median_ch.median, '0);
                end else begin
                    want = expected_medians.pop_front();
                    if (median_ch.median !== want) begin
                        report_mismatch("median", median_ch.median, want);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready)
                || (median_ch.valid && median_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_sliding_window_median: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : median_sink
        int stall;
        median_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 7);
            end else begin
                stall = 0;
            end
            if (stall == 0) begin
                median_ch.ready <= 1'b1;
            end else begin
                median_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    task automatic send_sample(input t_sample value);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        @(posedge i_clk);
        while (!sample_ch.ready) begin
            @(posedge i_clk);
        end
        samples_sent++;
        @(negedge i_clk);
    endtask

    task automatic end_phase();
        sample_ch.valid <= 1'b0;
        while (expected_medians.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length(input logic [WLEN_W-1:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_sample pick_sample(input t_value_mix mix);
        case (mix)
            VALUES_NARROW: begin
                return t_sample'(int'($urandom_range(0, 6)) - 3);
            end
            VALUES_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return t_sample'($urandom);
                endcase
            end
            default: begin
                return t_sample'($urandom);
            end
        endcase
    endfunction

    // length after reset, field extremes
    task automatic test_default_length();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        end_phase();
    endtask

    // zero acts as one, even length gives lower median, a write empties a partial window
    task automatic test_length_extremes();
        set_length(WLEN_W'(0));
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(32'sd5);
        end_phase();
        set_length(WLEN_W'(1));
        send_sample(-32'sd7);
        send_sample(32'sd7);
        end_phase();
        set_length(WLEN_W'(2));
        send_sample(32'sd10);
        send_sample(-32'sd10);
        send_sample(32'sd7);
        send_sample(32'sd7);
        end_phase();
        set_length(WLEN_W'(3));
        send_sample(32'sd100);
        send_sample(32'sd200);
        end_phase();
        set_length(WLEN_W'(3));
        send_sample(-32'sd100);
        send_sample(32'sd50);
        end_phase();
    endtask

    task automatic test_equal_samples();
        set_length(WLEN_W'(4));
        send_sample(32'sd5);
        send_sample(32'sd5);
        send_sample(32'sd5);
        send_sample(32'sd2);
        send_sample(32'sd5);
        send_sample(32'sd5);
        end_phase();
    endtask

    task automatic test_random_windows();
        int                phase;
        int                n;
        t_value_mix        mix;
        logic [WLEN_W-1:0] len;
        phase = 0;
        while (samples_sent < RANDOM_TARGET) begin
            case (phase)
                0: len = WLEN_W'(64);
                1: len = WLEN_W'(127);
                2: len = WLEN_W'(0);
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        len = WLEN_W'($urandom_range(17, 127));
                    end else begin
                        len = WLEN_W'($urandom_range(1, 16));
                    end
                end
            endcase
            set_length(len);
            mix     = t_value_mix'($urandom_range(0, 2));
            idle_on = ($urandom_range(0, 3) != 0);
            n       = effective_len(len) - 1 + $urandom_range(4, 40);
            repeat (n) send_sample(pick_sample(mix));
            end_phase();
            phase++;
        end
    endtask

    // receiver holds off while samples keep coming, so the input must stall
    task automatic test_output_hold();
        idle_on = 1'b0;
        set_length(WLEN_W'(5));
        hold_cycles = HOLD_LEN;
        repeat (90) send_sample(pick_sample(VALUES_ANY));
        end_phase();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        set_length(WLEN_W'(9));
        repeat (60) send_sample(pick_sample(VALUES_NARROW));
        end_phase();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        idle_on          = 1'b1;
        hold_cycles      = 0;
        error_count      = 0;
        samples_sent     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_length();
        test_length_extremes();
        test_equal_samples();
        test_random_windows();
        test_output_hold();
        test_steady_stream();

        if (error_count == 0) begin
            $display("tb_sliding_window_median: clean");
        end else begin
            $display("tb_sliding_window_median: errors");
        end
        $finish;
    end

endmodule
